// ===== sv/ers_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_pkg
// Shared sizes, register indexes and state codes of the Euclidean rhythm step
// generator.
// ----------------------------------------------------------------------------
package ers_pkg;

    localparam int MAX_STEPS   = 64;
    localparam int IDX_W       = $clog2(MAX_STEPS);
    localparam int CNT_W       = $clog2(MAX_STEPS + 1);
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int WIDE_W      = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    // Euclid chain on n <= MAX_STEPS is well below two levels per bit
    localparam int MAX_LEVELS  = 2 * $clog2(MAX_STEPS);
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    // two pattern banks: one is read while the next level is written
    localparam int RAM_DEPTH   = 2 * MAX_STEPS;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);

    localparam logic [CFG_W-1:0] STEP_COUNT_RESET  = CFG_W'(16);
    localparam logic [CFG_W-1:0] PULSE_COUNT_RESET = CFG_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_COUNT  = CFG_IDX_W'(0),
        REG_PULSE_COUNT = CFG_IDX_W'(1)
    } ers_reg_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_DIV,
        ST_PREP,
        ST_WRITE,
        ST_RUN
    } ers_state_t;

endpackage

// ===== sv/ers_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module ers_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/euclidean_rhythm_step_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_rhythm_step_generator
// Plays a Euclidean rhythm of pulse_count onsets over step_count steps out of
// a pattern RAM that is rebuilt level by level from the Euclid chain.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | restart
//   out     | output    | out_valid/out_stall| onset, step_index, cycle_end
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One tick per cycle while in_stall is low; each result passes the RAM read
// register, then the output register. A second result register lets one more
// tick in while the output is stalled.
// After reset and after every write to REG_STEP_COUNT or REG_PULSE_COUNT the
// pattern is rebuilt: one subtract per cycle down the Euclid chain, then one
// RAM write per step for each level. Ticks are held off with in_stall until
// the build is done.
// ----------------------------------------------------------------------------
module euclidean_rhythm_step_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    // tick channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           restart,
    // step channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           onset,
    output logic [ers_pkg::IDX_W-1:0]      step_index,
    output logic                           cycle_end,
    // register writes
    input  logic                           cfg_we,
    input  logic [ers_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ers_pkg::CFG_W-1:0]      cfg_data
);

    import ers_pkg::*;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p,
                                                  input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] p1;
        p1 = CNT_W'(p) + CNT_W'(1);
        return (p1 == len) ? '0 : IDX_W'(p1);
    endfunction

    // configuration
    logic [CFG_W-1:0]  step_count_reg, pulse_count_reg;
    logic              cfg_hit;
    logic [CNT_W-1:0]  n_eff, k_eff;

    // build sequencer
    ers_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  b_reg, b_next;
    logic [CNT_W-1:0]  a_reg, a_next;
    logic [CNT_W-1:0]  div_rem_reg, div_rem_next;
    logic [CNT_W-1:0]  q_reg, q_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [LVL_W-1:0]  depth_reg, depth_next;
    logic [LVL_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  lv_n_reg, lv_n_next;
    logic [CNT_W-1:0]  lv_k_reg, lv_k_next;
    logic [CNT_W-1:0]  lv_q_reg, lv_q_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  zero_cnt_reg, zero_cnt_next;
    logic [IDX_W-1:0]  w_reg, w_next;
    logic              wbank_reg, wbank_next;
    logic              play_bank_reg, play_bank_next;
    logic              lvl_we;
    logic [IDX_W-1:0]  init_ptr;
    logic              is_base;
    logic              extra;

    logic [CNT_W-1:0]  lvl_n_reg [MAX_LEVELS];
    logic [CNT_W-1:0]  lvl_k_reg [MAX_LEVELS];
    logic [CNT_W-1:0]  lvl_q_reg [MAX_LEVELS];

    // pattern RAM
    logic              ram_we, ram_re, ram_wdata, ram_rdata;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr, build_raddr;

    // playback
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  play_pos;
    logic              play_last;
    logic              accept;
    logic              a_valid_reg, a_end_reg;
    logic [IDX_W-1:0]  a_idx_reg;
    logic              b_valid_reg, b_onset_reg, b_end_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic              b_free, a_move, a_free;

    // ------------------------------------------------------------------
    // configuration registers and clamping
    // ------------------------------------------------------------------
    always_comb
    begin
        cfg_hit = 1'b0;
        unique case (cfg_index)
            REG_STEP_COUNT:  cfg_hit = cfg_we;
            REG_PULSE_COUNT: cfg_hit = cfg_we;
            default:         cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg  <= STEP_COUNT_RESET;
            pulse_count_reg <= PULSE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_STEP_COUNT)
            begin
                step_count_reg <= cfg_data;
            end
            if (cfg_index == REG_PULSE_COUNT)
            begin
                pulse_count_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (step_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (WIDE_W'(step_count_reg) > WIDE_W'(MAX_STEPS))
            n_eff = CNT_W'(MAX_STEPS);
        else
            n_eff = CNT_W'(step_count_reg);

        if (pulse_count_reg == '0)
            k_eff = CNT_W'(1);
        else if (WIDE_W'(pulse_count_reg) > WIDE_W'(n_eff))
            k_eff = n_eff;
        else
            k_eff = CNT_W'(pulse_count_reg);
    end

    // ------------------------------------------------------------------
    // build sequencer: Euclid chain, then one pattern level per pass
    // ------------------------------------------------------------------
    assign is_base  = (cur_reg == depth_reg);
    assign init_ptr = (lvl_k_reg[cur_reg] == CNT_W'(1)) ? '0 : IDX_W'(1);
    assign extra    = is_base ? 1'b0 : ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            wbank_reg     <= 1'b0;
            play_bank_reg <= 1'b0;
            lvl_reg       <= '0;
            depth_reg     <= '0;
            cur_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wbank_reg     <= wbank_next;
            play_bank_reg <= play_bank_next;
            lvl_reg       <= lvl_next;
            depth_reg     <= depth_next;
            cur_reg       <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        div_rem_reg  <= div_rem_next;
        q_reg        <= q_next;
        lv_n_reg     <= lv_n_next;
        lv_k_reg     <= lv_k_next;
        lv_q_reg     <= lv_q_next;
        ptr_reg      <= ptr_next;
        zero_cnt_reg <= zero_cnt_next;
        w_reg        <= w_next;
        if (lvl_we)
        begin
            lvl_n_reg[lvl_reg] <= a_reg;
            lvl_k_reg[lvl_reg] <= b_reg;
            lvl_q_reg[lvl_reg] <= q_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        div_rem_next   = div_rem_reg;
        q_next         = q_reg;
        lvl_next       = lvl_reg;
        depth_next     = depth_reg;
        cur_next       = cur_reg;
        lv_n_next      = lv_n_reg;
        lv_k_next      = lv_k_reg;
        lv_q_next      = lv_q_reg;
        ptr_next       = ptr_reg;
        zero_cnt_next  = zero_cnt_reg;
        w_next         = w_reg;
        wbank_next     = wbank_reg;
        play_bank_next = play_bank_reg;
        lvl_we         = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = 1'b0;
        ram_waddr      = {wbank_reg, w_reg};
        build_raddr    = {~wbank_reg, ptr_reg};

        unique case (state_reg)
            ST_INIT:
            begin
                a_next       = n_eff;
                b_next       = k_eff;
                div_rem_next = n_eff;
                q_next       = '0;
                lvl_next     = '0;
                wbank_next   = 1'b0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rem_reg >= b_reg)
                begin
                    div_rem_next = div_rem_reg - b_reg;
                    q_next       = q_reg + CNT_W'(1);
                end
                else
                begin
                    lvl_we = 1'b1;
                    if (div_rem_reg == '0)
                    begin
                        depth_next = lvl_reg;
                        cur_next   = lvl_reg;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        // descend to (k, r)
                        a_next       = b_reg;
                        b_next       = div_rem_reg;
                        div_rem_next = b_reg;
                        q_next       = '0;
                        lvl_next     = lvl_reg + LVL_W'(1);
                    end
                end
            end
            ST_PREP:
            begin
                lv_n_next     = lvl_n_reg[cur_reg];
                lv_k_next     = lvl_k_reg[cur_reg];
                lv_q_next     = lvl_q_reg[cur_reg];
                // fetch the lower-level bit for gap 0 now, gap 1 during gap 0
                build_raddr   = {~wbank_reg, init_ptr};
                ptr_next      = wrap_inc(init_ptr, lvl_k_reg[cur_reg]);
                zero_cnt_next = '0;
                w_next        = '0;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                ram_we    = 1'b1;
                ram_wdata = (zero_cnt_reg == '0);
                if (zero_cnt_reg == '0)
                    zero_cnt_next = lv_q_reg + CNT_W'(extra) - CNT_W'(1);
                else
                    zero_cnt_next = zero_cnt_reg - CNT_W'(1);
                if (zero_cnt_next == '0)
                    ptr_next = wrap_inc(ptr_reg, lv_k_reg);
                w_next = w_reg + IDX_W'(1);
                if (CNT_W'(w_reg) + CNT_W'(1) == lv_n_reg)
                begin
                    wbank_next = ~wbank_reg;
                    if (cur_reg == '0)
                    begin
                        play_bank_next = wbank_reg;
                        state_next     = ST_RUN;
                    end
                    else
                    begin
                        cur_next   = cur_reg - LVL_W'(1);
                        state_next = ST_PREP;
                    end
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        // a write to the step or pulse count register starts the build over
        if (cfg_hit)
            state_next = ST_INIT;
    end

    // ------------------------------------------------------------------
    // pattern RAM
    // ------------------------------------------------------------------
    assign ram_raddr = (state_reg == ST_RUN) ? {play_bank_reg, play_pos} : build_raddr;
    assign ram_re    = (state_reg == ST_RUN) ? accept : 1'b1;

    ers_ram #(
        .WIDTH (1),
        .DEPTH (RAM_DEPTH)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // playback: position, RAM read stage, output register
    // ------------------------------------------------------------------
    assign b_free   = !b_valid_reg || !out_stall;
    assign a_move   = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || a_move;
    assign in_stall = (state_reg != ST_RUN) || !a_free;
    assign accept   = in_valid && !in_stall;

    assign play_pos  = (restart || (CNT_W'(pos_reg) >= n_eff)) ? '0 : pos_reg;
    assign play_last = (CNT_W'(play_pos) + CNT_W'(1) == n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                pos_reg <= play_last ? '0 : play_pos + IDX_W'(1);

            if (accept)
                a_valid_reg <= 1'b1;
            else if (a_move)
                a_valid_reg <= 1'b0;

            if (a_move)
                b_valid_reg <= 1'b1;
            else if (b_free)
                b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_idx_reg <= play_pos;
            a_end_reg <= play_last;
        end
        if (a_move)
        begin
            b_onset_reg <= ram_rdata;
            b_idx_reg   <= a_idx_reg;
            b_end_reg   <= a_end_reg;
        end
    end

    assign out_valid  = b_valid_reg;
    assign onset      = b_onset_reg;
    assign step_index = b_idx_reg;
    assign cycle_end  = b_end_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_tick_while_building: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == ST_RUN))
        else $error("tick transfer while the pattern is being built");

    a_ptr_in_lower_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (CNT_W'(ptr_reg) < lv_k_reg))
        else $error("lower-level read pointer outside its pattern");

    a_write_in_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (CNT_W'(w_reg) < lv_n_reg))
        else $error("pattern write past the end of its level");

    a_step_zero_onset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (step_index == '0)) |-> onset)
        else $error("step zero of the cycle is not an onset");

    a_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && play_last) |=> (pos_reg == '0))
        else $error("position did not wrap after the last step");

endmodule
